FILE: rtl/psl_pkg.sv
// Package for the planar velocity slew limiter.
// Item, configuration, command and status types plus shared constants.
// No dependencies.
package psl_pkg;

	localparam int VAL_W      = 32;
	localparam int REG_W      = 31;
	localparam int DT_W       = 16;
	localparam int DT_FRAC    = 16;
	localparam int MUL_W      = 33;
	localparam int SQRT_STEPS = 33;
	localparam int DIV_STEPS  = 31;
	localparam int CNT_W      = 6;
	localparam int ADDR_W     = 4;

	// register indexes
	typedef enum logic [1:0] {
		REG_LIN_ACCEL = 2'd0,
		REG_ANG_ACCEL = 2'd1,
		REG_LIN_TOL   = 2'd2,
		REG_ANG_TOL   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [REG_W-1:0] linear_accel;
		logic [REG_W-1:0] angular_accel;
		logic [REG_W-1:0] linear_snap_tolerance;
		logic [REG_W-1:0] angular_snap_tolerance;
	} cfg_t;

	typedef struct packed {
		logic                    func;
		logic signed [VAL_W-1:0] target_vx;
		logic signed [VAL_W-1:0] target_vy;
		logic signed [VAL_W-1:0] target_yaw_rate;
		logic [DT_W-1:0]         time_step;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] out_vx;
		logic signed [VAL_W-1:0] out_vy;
		logic signed [VAL_W-1:0] out_yaw_rate;
	} out_item_t;

	// datapath commands
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_LOAD,
		OP_LIMLIN,
		OP_LIMANG,
		OP_SQX,
		OP_SQY,
		OP_LIMSQ,
		OP_TAKE,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_NUMX,
		OP_NUMY,
		OP_DIV_STEP,
		OP_APPLY,
		OP_SNAPX,
		OP_SNAPY,
		OP_TOLSQ,
		OP_FINISH,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		logic is_load;
		logic dt_zero;
		logic in_reach;
	} dp_status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_LOAD,
		S_LIMLIN,
		S_LIMANG,
		S_SQX,
		S_SQY,
		S_LIMSQ,
		S_CHECK,
		S_TAKE,
		S_SQRT_INIT,
		S_SQRT,
		S_NUMX,
		S_NUMY,
		S_DIV,
		S_APPLY,
		S_SNAPX,
		S_SNAPY,
		S_TOLSQ,
		S_FINISH,
		S_PUBLISH
	} state_t;

endpackage

FILE: rtl/psl_regs.sv
// APB-style configuration registers of the slew limiter.
// Depends on psl_pkg.
module psl_regs
	import psl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.linear_accel           <= REG_W'(1 << 16);
			cfg_q.angular_accel          <= REG_W'(1 << 16);
			cfg_q.linear_snap_tolerance  <= '0;
			cfg_q.angular_snap_tolerance <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_LIN_ACCEL: cfg_q.linear_accel           <= pwdata[REG_W-1:0];
				REG_ANG_ACCEL: cfg_q.angular_accel          <= pwdata[REG_W-1:0];
				REG_LIN_TOL:   cfg_q.linear_snap_tolerance  <= pwdata[REG_W-1:0];
				REG_ANG_TOL:   cfg_q.angular_snap_tolerance <= pwdata[REG_W-1:0];
				default:       ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_LIN_ACCEL: prdata = {1'b0, cfg_q.linear_accel};
			REG_ANG_ACCEL: prdata = {1'b0, cfg_q.angular_accel};
			REG_LIN_TOL:   prdata = {1'b0, cfg_q.linear_snap_tolerance};
			REG_ANG_TOL:   prdata = {1'b0, cfg_q.angular_snap_tolerance};
			default:       prdata = '0;
		endcase
	end

endmodule

FILE: rtl/psl_dp.sv
// Datapath of the slew limiter: velocity state, shared 33x33 multiplier,
// bit-serial square root and two restoring dividers. Depends on psl_pkg.
module psl_dp
	import psl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_op_t     op,
	input  in_item_t   in_item,
	input  cfg_t       cfg,
	output dp_status_t status,
	output out_item_t  out_item
);

	// latched item
	logic              func_q;
	logic [VAL_W-1:0]  tx_q, ty_q, tw_q;
	logic [DT_W-1:0]   dt_q;
	// velocity state
	logic [VAL_W-1:0]  cur_vx_q, cur_vy_q, cur_yaw_q;
	// intermediates
	logic [REG_W-1:0]  lim_lin_q, lim_ang_q;
	logic [VAL_W:0]    dx_q, dy_q, dw_q;
	logic [VAL_W:0]    ax_q, ay_q, aw_q;
	logic [63:0]       sqx_q, sqy_q;
	logic [64:0]       sum_q;
	logic [61:0]       limsq_q;
	logic [65:0]       rad_q;
	logic [35:0]       srem_q;
	logic [32:0]       root_q;
	logic [62:0]       numx_q;
	logic [32:0]       remx_q, remy_q;
	logic [REG_W-1:0]  lowx_q, lowy_q, qx_q, qy_q;
	logic [VAL_W-1:0]  vx_nx_q, vy_nx_q, yaw_nx_q;
	logic [62:0]       vx2_q, vy2_q;
	logic [61:0]       tolsq_q;
	out_item_t         out_q;

	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [2*MUL_W-1:0] prod;
	logic [VAL_W:0]     dx, dy, dw, mvx, mvy;
	logic [35:0]        srem2, strial;
	logic [33:0]        r2x, r2y, dsor;
	logic [VAL_W:0]     yaw_step, yaw_mv, yaw_mag;
	logic [VAL_W-1:0]   yaw_new;
	logic [63:0]        vsum;
	logic               psnap, ysnap;

	function automatic logic [VAL_W:0] mag33(input logic [VAL_W:0] v);
		mag33 = v[VAL_W] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [VAL_W:0] sx(input logic [VAL_W-1:0] v);
		sx = {v[VAL_W-1], v};
	endfunction

	assign status.is_load  = func_q;
	assign status.dt_zero  = (dt_q == '0);
	assign status.in_reach = (sum_q <= {3'b0, limsq_q});
	assign out_item        = out_q;

	// differences against the target
	assign dx = sx(tx_q) - sx(cur_vx_q);
	assign dy = sx(ty_q) - sx(cur_vy_q);
	assign dw = sx(tw_q) - sx(cur_yaw_q);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			OP_LIMLIN: begin
				mul_a = MUL_W'(cfg.linear_accel);
				mul_b = MUL_W'(dt_q);
			end
			OP_LIMANG: begin
				mul_a = MUL_W'(cfg.angular_accel);
				mul_b = MUL_W'(dt_q);
			end
			OP_SQX: begin
				mul_a = ax_q;
				mul_b = ax_q;
			end
			OP_SQY: begin
				mul_a = ay_q;
				mul_b = ay_q;
			end
			OP_LIMSQ: begin
				mul_a = MUL_W'(lim_lin_q);
				mul_b = MUL_W'(lim_lin_q);
			end
			OP_NUMX: begin
				mul_a = ax_q;
				mul_b = MUL_W'(lim_lin_q);
			end
			OP_NUMY: begin
				mul_a = ay_q;
				mul_b = MUL_W'(lim_lin_q);
			end
			OP_SNAPX: begin
				mul_a = mag33(sx(vx_nx_q));
				mul_b = mag33(sx(vx_nx_q));
			end
			OP_SNAPY: begin
				mul_a = mag33(sx(vy_nx_q));
				mul_b = mag33(sx(vy_nx_q));
			end
			OP_TOLSQ: begin
				mul_a = MUL_W'(cfg.linear_snap_tolerance);
				mul_b = MUL_W'(cfg.linear_snap_tolerance);
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	// square root step: two radicand bits per cycle
	assign srem2  = {srem_q[33:0], rad_q[65:64]};
	assign strial = {1'b0, root_q, 2'b01};

	// divider step: one quotient bit per cycle on both axes; the root can
	// reach 33 bits, so the shifted remainder needs 34
	assign r2x  = {remx_q, lowx_q[REG_W-1]};
	assign r2y  = {remy_q, lowy_q[REG_W-1]};
	assign dsor = {1'b0, root_q};

	// signed moves along the difference vector
	assign mvx = dx_q[VAL_W] ? (~{2'b0, qx_q} + 1'b1) : {2'b0, qx_q};
	assign mvy = dy_q[VAL_W] ? (~{2'b0, qy_q} + 1'b1) : {2'b0, qy_q};

	// yaw rate scalar slew
	assign yaw_step = {2'b0, lim_ang_q};
	assign yaw_mv   = dw_q[VAL_W] ? (sx(cur_yaw_q) - yaw_step) : (sx(cur_yaw_q) + yaw_step);
	assign yaw_new  = (aw_q <= yaw_step) ? tw_q : yaw_mv[VAL_W-1:0];

	// snap decisions
	assign vsum    = {1'b0, vx2_q} + {1'b0, vy2_q};
	assign psnap   = vsum < {2'b0, tolsq_q};
	assign yaw_mag = mag33(sx(yaw_nx_q));
	assign ysnap   = yaw_mag < {2'b0, cfg.angular_snap_tolerance};

	// velocity state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vx_q  <= '0;
			cur_vy_q  <= '0;
			cur_yaw_q <= '0;
		end else if (op == OP_LOAD) begin
			cur_vx_q  <= tx_q;
			cur_vy_q  <= ty_q;
			cur_yaw_q <= tw_q;
		end else if (op == OP_FINISH) begin
			cur_vx_q  <= psnap ? '0 : vx_nx_q;
			cur_vy_q  <= psnap ? '0 : vy_nx_q;
			cur_yaw_q <= ysnap ? '0 : yaw_nx_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LATCH: begin
				func_q <= in_item.func;
				tx_q   <= in_item.target_vx;
				ty_q   <= in_item.target_vy;
				tw_q   <= in_item.target_yaw_rate;
				dt_q   <= in_item.time_step;
			end
			OP_LIMLIN: begin
				lim_lin_q <= prod[DT_FRAC +: REG_W];
				dx_q      <= dx;
				dy_q      <= dy;
				dw_q      <= dw;
				ax_q      <= mag33(dx);
				ay_q      <= mag33(dy);
				aw_q      <= mag33(dw);
			end
			OP_LIMANG: lim_ang_q <= prod[DT_FRAC +: REG_W];
			OP_SQX:    sqx_q <= prod[63:0];
			OP_SQY:    sqy_q <= prod[63:0];
			OP_LIMSQ: begin
				limsq_q <= prod[61:0];
				sum_q   <= {1'b0, sqx_q} + {1'b0, sqy_q};
			end
			OP_TAKE: begin
				vx_nx_q <= tx_q;
				vy_nx_q <= ty_q;
			end
			OP_SQRT_INIT: begin
				rad_q  <= {1'b0, sum_q};
				srem_q <= '0;
				root_q <= '0;
			end
			OP_SQRT_STEP: begin
				rad_q <= {rad_q[63:0], 2'b00};
				if (srem2 >= strial) begin
					srem_q <= srem2 - strial;
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					srem_q <= srem2;
					root_q <= {root_q[31:0], 1'b0};
				end
			end
			OP_NUMX: numx_q <= prod[62:0];
			OP_NUMY: begin
				remx_q <= {1'b0, numx_q[62:REG_W]};
				lowx_q <= numx_q[REG_W-1:0];
				remy_q <= {1'b0, prod[62:REG_W]};
				lowy_q <= prod[REG_W-1:0];
				qx_q   <= '0;
				qy_q   <= '0;
			end
			OP_DIV_STEP: begin
				lowx_q <= {lowx_q[REG_W-2:0], 1'b0};
				lowy_q <= {lowy_q[REG_W-2:0], 1'b0};
				if (r2x >= dsor) begin
					remx_q <= 33'(r2x - dsor);
					qx_q   <= {qx_q[REG_W-2:0], 1'b1};
				end else begin
					remx_q <= r2x[32:0];
					qx_q   <= {qx_q[REG_W-2:0], 1'b0};
				end
				if (r2y >= dsor) begin
					remy_q <= 33'(r2y - dsor);
					qy_q   <= {qy_q[REG_W-2:0], 1'b1};
				end else begin
					remy_q <= r2y[32:0];
					qy_q   <= {qy_q[REG_W-2:0], 1'b0};
				end
			end
			OP_APPLY: begin
				vx_nx_q <= VAL_W'(sx(cur_vx_q) + mvx);
				vy_nx_q <= VAL_W'(sx(cur_vy_q) + mvy);
			end
			OP_SNAPX: begin
				vx2_q    <= prod[62:0];
				yaw_nx_q <= yaw_new;
			end
			OP_SNAPY: vy2_q   <= prod[62:0];
			OP_TOLSQ: tolsq_q <= prod[61:0];
			OP_FINISH: begin
				out_q.out_vx       <= psnap ? '0 : vx_nx_q;
				out_q.out_vy       <= psnap ? '0 : vy_nx_q;
				out_q.out_yaw_rate <= ysnap ? '0 : yaw_nx_q;
			end
			OP_PUBLISH: begin
				out_q.out_vx       <= cur_vx_q;
				out_q.out_vy       <= cur_vy_q;
				out_q.out_yaw_rate <= cur_yaw_q;
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	// the planar move never exceeds the step limit
	a_move_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_APPLY) |-> (qx_q <= lim_lin_q && qy_q <= lim_lin_q))
		else $error("planar move exceeds limit");
`endif

endmodule

FILE: rtl/psl_ctrl.sv
// Controller of the slew limiter: sequences datapath commands per item
// and owns the handshake flags. Depends on psl_pkg.
module psl_ctrl
	import psl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output logic       in_stall,
	output logic       out_valid,
	output dp_op_t     op
);

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             last_sqrt, last_div;

	assign out_free  = !out_valid_q || !out_stall;
	assign last_sqrt = (cnt_q == CNT_W'(SQRT_STEPS - 1));
	assign last_div  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_nx = S_DISPATCH;
			S_DISPATCH: begin
				if (status.is_load)      state_nx = S_LOAD;
				else if (status.dt_zero) state_nx = S_PUBLISH;
				else                     state_nx = S_LIMLIN;
			end
			S_LOAD:      state_nx = S_PUBLISH;
			S_LIMLIN:    state_nx = S_LIMANG;
			S_LIMANG:    state_nx = S_SQX;
			S_SQX:       state_nx = S_SQY;
			S_SQY:       state_nx = S_LIMSQ;
			S_LIMSQ:     state_nx = S_CHECK;
			S_CHECK:     state_nx = status.in_reach ? S_TAKE : S_SQRT_INIT;
			S_TAKE:      state_nx = S_SNAPX;
			S_SQRT_INIT: state_nx = S_SQRT;
			S_SQRT:      if (last_sqrt) state_nx = S_NUMX;
			S_NUMX:      state_nx = S_NUMY;
			S_NUMY:      state_nx = S_DIV;
			S_DIV:       if (last_div) state_nx = S_APPLY;
			S_APPLY:     state_nx = S_SNAPX;
			S_SNAPX:     state_nx = S_SNAPY;
			S_SNAPY:     state_nx = S_TOLSQ;
			S_TOLSQ:     state_nx = S_FINISH;
			S_FINISH:    if (out_free) state_nx = S_IDLE;
			S_PUBLISH:   if (out_free) state_nx = S_IDLE;
			default:     state_nx = S_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		unique case (state_q)
			S_IDLE:      op = in_valid ? OP_LATCH : OP_NONE;
			S_LOAD:      op = OP_LOAD;
			S_LIMLIN:    op = OP_LIMLIN;
			S_LIMANG:    op = OP_LIMANG;
			S_SQX:       op = OP_SQX;
			S_SQY:       op = OP_SQY;
			S_LIMSQ:     op = OP_LIMSQ;
			S_TAKE:      op = OP_TAKE;
			S_SQRT_INIT: op = OP_SQRT_INIT;
			S_SQRT:      op = OP_SQRT_STEP;
			S_NUMX:      op = OP_NUMX;
			S_NUMY:      op = OP_NUMY;
			S_DIV:       op = OP_DIV_STEP;
			S_APPLY:     op = OP_APPLY;
			S_SNAPX:     op = OP_SNAPX;
			S_SNAPY:     op = OP_SNAPY;
			S_TOLSQ:     op = OP_TOLSQ;
			S_FINISH:    op = out_free ? OP_FINISH : OP_NONE;
			S_PUBLISH:   op = out_free ? OP_PUBLISH : OP_NONE;
			default:     op = OP_NONE;
		endcase
	end

	// state, iteration counter and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if ((state_q == S_SQRT && !last_sqrt) || (state_q == S_DIV && !last_div))
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (op == OP_FINISH || op == OP_PUBLISH)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	// a result is written only into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_FINISH || op == OP_PUBLISH) |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten");
	// an accepted item starts dispatch on the next cycle
	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DISPATCH))
		else $error("accepted item not dispatched");
	// iteration counter stays inside the longest loop
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(SQRT_STEPS))
		else $error("iteration counter out of range");
`endif

endmodule

FILE: rtl/planar_velocity_slew_limiter_top.sv
// Top level of the planar velocity slew limiter.
// Depends on psl_pkg, psl_regs, psl_ctrl and psl_dp.
//
//  channel   handshake              payload
//  in        in_valid / in_stall    in_item  (in_item_t)
//  out       out_valid / out_stall  out_item (out_item_t)
//  config    psel/penable/pwrite    paddr, pwdata, prdata
//
// A load item sets the velocity and a zero time step leaves it as it was. A step whose
// target is in reach takes the target; otherwise the bit-serial square root runs first,
// followed by the divider pair that runs both axes together.
// Reset clears the velocity to zero and the registers to their defaults.
// A stalled result waits in the output register while the next item is taken.
module planar_velocity_slew_limiter_top
	import psl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t       cfg;
	dp_op_t     op;
	dp_status_t status;

	psl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.status    (status),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.op        (op)
	);

	psl_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.in_item  (in_item),
		.cfg      (cfg),
		.status   (status),
		.out_item (out_item)
	);

endmodule

FILE: bench/psl_checker.sv
// Result checker for the planar velocity slew limiter.
// Watches the in, out and config channels, predicts each result, compares it.
// Depends on psl_pkg.
`timescale 1ns / 1ps

module psl_checker
	import psl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  in_item_t          in_item,
	input  logic              out_valid,
	input  logic              out_stall,
	input  out_item_t         out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output int                fail_count,
	output int                pending
);

	// predictor copy of configuration and velocity
	logic [REG_W-1:0] lin_acc, ang_acc, lin_tol, ang_tol;
	logic signed [63:0] vel_x, vel_y, vel_w;
	out_item_t velocity_q[$];
	int errs;

	// floor square root of a 66-bit value
	function automatic logic [63:0] root66(input logic [65:0] v);
		logic [63:0] r;
		logic [67:0] rem, trial;
		r = 0;
		rem = 0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | v[2*i +: 2];
			trial = {r, 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				r = {r[62:0], 1'b1};
			end else begin
				r = {r[62:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] absv(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	// move of one axis along the difference vector, truncated toward zero
	function automatic logic signed [63:0] axis_move(input logic signed [63:0] d,
			input logic [63:0] lim, input logic [63:0] span);
		logic [127:0] m;
		m = (128'(absv(d)) * lim) / span;
		return d < 0 ? -$signed(m[63:0]) : $signed(m[63:0]);
	endfunction

	task automatic slew_velocity(input in_item_t it);
		logic [63:0] lim_l, lim_a, span;
		logic signed [63:0] tx, ty, tw, dx, dy, dw;
		logic [65:0] sum, lsq, vsq, tsq;
		out_item_t r;
		tx = it.target_vx;
		ty = it.target_vy;
		tw = it.target_yaw_rate;
		if (it.func) begin
			vel_x = tx;
			vel_y = ty;
			vel_w = tw;
		end else if (it.time_step != 0) begin
			lim_l = (64'(lin_acc) * it.time_step) >> DT_FRAC;
			lim_a = (64'(ang_acc) * it.time_step) >> DT_FRAC;
			dx = tx - vel_x;
			dy = ty - vel_y;
			dw = tw - vel_w;
			sum = 66'(absv(dx)) * absv(dx) + 66'(absv(dy)) * absv(dy);
			lsq = 66'(lim_l) * lim_l;
			if (sum <= lsq) begin
				vel_x = tx;
				vel_y = ty;
			end else begin
				span = root66(sum);
				vel_x = vel_x + axis_move(dx, lim_l, span);
				vel_y = vel_y + axis_move(dy, lim_l, span);
			end
			vsq = 66'(absv(vel_x)) * absv(vel_x) + 66'(absv(vel_y)) * absv(vel_y);
			tsq = 66'(lin_tol) * lin_tol;
			if (vsq < tsq) begin
				vel_x = 0;
				vel_y = 0;
			end
			if (absv(dw) <= lim_a) vel_w = tw;
			else if (dw < 0) vel_w = vel_w - $signed(lim_a);
			else vel_w = vel_w + $signed(lim_a);
			if (absv(vel_w) < ang_tol) vel_w = 0;
		end
		r.out_vx = vel_x[31:0];
		r.out_vy = vel_y[31:0];
		r.out_yaw_rate = vel_w[31:0];
		velocity_q.push_back(r);
	endtask

	assign pending = velocity_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_acc <= 31'd65536;
			ang_acc <= 31'd65536;
			lin_tol <= '0;
			ang_tol <= '0;
			vel_x = 0;
			vel_y = 0;
			vel_w = 0;
			velocity_q.delete();
			fail_count <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_LIN_ACCEL: lin_acc <= pwdata[30:0];
					REG_ANG_ACCEL: ang_acc <= pwdata[30:0];
					REG_LIN_TOL:   lin_tol <= pwdata[30:0];
					REG_ANG_TOL:   ang_tol <= pwdata[30:0];
				endcase
			end
			// compare results
			if (out_valid && !out_stall) begin
				errs = 0;
				if (velocity_q.size() == 0) begin
					$error("unexpected result %h", out_item);
					errs = 1;
				end else begin
					out_item_t e;
					e = velocity_q.pop_front();
					if (e.out_vx !== out_item.out_vx) begin
						$error("out_vx exp %h got %h", e.out_vx, out_item.out_vx);
						errs = errs + 1;
					end
					if (e.out_vy !== out_item.out_vy) begin
						$error("out_vy exp %h got %h", e.out_vy, out_item.out_vy);
						errs = errs + 1;
					end
					if (e.out_yaw_rate !== out_item.out_yaw_rate) begin
						$error("out_yaw_rate exp %h got %h", e.out_yaw_rate,
							out_item.out_yaw_rate);
						errs = errs + 1;
					end
				end
				if (errs != 0) fail_count <= fail_count + errs;
			end
			// predict after compare so a same-cycle item queues behind
			if (in_valid && !in_stall) slew_velocity(in_item);
		end
	end

endmodule

FILE: bench/testbench.sv
// Testbench top for the planar velocity slew limiter.
// Drives items and register writes, gives the verdict; depends on psl_pkg,
// psl_checker and the block.
`timescale 1ns / 1ps

module testbench;
	import psl_pkg::*;

	logic              clk, arst_n;
	logic              in_valid, in_stall, out_valid, out_stall;
	in_item_t          in_item;
	out_item_t         out_item;
	logic              psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata, prdata;
	int                fail_count, pending;
	int                send_idle, recv_idle;
	longint            cycles = 0;

	planar_velocity_slew_limiter_top u_dut (.*);

	psl_checker u_chk (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("[planar_velocity_slew_limiter_top] ERROR");
			$finish;
		end
	end

	// receiver stall
	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = ADDR_W'(idx) << 2;
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic drain;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	// in_stall only moves after a rising edge, so it is checked at the
	// falling edge ahead of the accepting edge
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle) @(negedge clk);
		in_valid = 1'b1;
		in_item = it;
		while (in_stall) @(negedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_vel();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(1 << 20)) - (1 << 19);
			2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
			default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it.func = ($urandom_range(9) == 0);
		it.target_vx = rand_vel();
		it.target_vy = rand_vel();
		it.target_yaw_rate = rand_vel();
		case ($urandom_range(3))
			0: it.time_step = 16'h0000;
			1: it.time_step = 16'hffff;
			default: it.time_step = 16'($urandom);
		endcase
		return it;
	endfunction

	function automatic in_item_t mk(input int f, input int x, y, w, input int dt);
		in_item_t it;
		it.func = 1'(f);
		it.target_vx = 32'(x);
		it.target_vy = 32'(y);
		it.target_yaw_rate = 32'(w);
		it.time_step = 16'(dt);
		return it;
	endfunction

	task automatic set_regs(input logic [31:0] la, aa, lt, at);
		write_reg(REG_LIN_ACCEL, la);
		write_reg(REG_ANG_ACCEL, aa);
		write_reg(REG_LIN_TOL, lt);
		write_reg(REG_ANG_TOL, at);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle = 0;
		recv_idle = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset defaults, loads, zero step, reach, extremes
		send_item(mk(0, 32'h0001_0000, 0, 32'hffff_0000, 16'hffff));
		send_item(mk(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h8000));
		send_item(mk(1, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'h1234));
		send_item(mk(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'hffff));
		send_item(mk(0, 32'h0, 32'h0, 32'h0, 16'h0));
		send_item(mk(1, 0, 0, 0, 0));
		send_item(mk(0, 32'h100, 32'h200, 32'h80, 16'h1));
		drain();
		set_regs(32'h7fffffff, 32'h7fffffff, 32'h0001_0000, 32'h0002_0000);
		send_item(mk(0, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 16'hffff));
		send_item(mk(0, 32'h80000000, 32'h80000000, 32'h80000000, 16'hffff));
		send_item(mk(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h0001));
		drain();
		set_regs(32'h1, 32'h1, 32'h7fffffff, 32'h7fffffff);
		send_item(mk(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
		send_item(mk(0, 0, 0, 0, 16'hffff));
		send_item(mk(1, 32'h1000, 32'h2000, 32'h80000000, 0));
		send_item(mk(0, 32'h1000, 32'h2000, 32'h80000000, 16'hffff));
		drain();

		// random phases with varying settings and idle mixes
		for (int ph = 0; ph < 9; ph++) begin
			case (ph % 3)
				0: begin send_idle = 23; recv_idle = 82; end
				1: begin send_idle = 82; recv_idle = 23; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			if (ph == 8) set_regs(32'h0001_0000, 32'h0001_0000, 0, 0);
			else set_regs($urandom_range(1) ? 32'($urandom_range(32'h7fffffff, 1))
					: 32'($urandom_range(32'h40000, 1)),
				32'($urandom_range(32'h7fffffff, 1)),
				$urandom_range(1) ? 32'($urandom_range(32'h7fffffff)) : 32'h0,
				$urandom_range(1) ? 32'($urandom_range(32'h20000)) : 32'h0);
			for (int n = 0; n < 122; n++) begin
				send_item(rand_item());
				if (n == 60) while (pending != 0) @(negedge clk);
			end
			drain();
		end

		if (fail_count == 0)
			$display("[planar_velocity_slew_limiter_top] OK");
		else
			$display("[planar_velocity_slew_limiter_top] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/psl_pkg.sv
rtl/psl_regs.sv
rtl/psl_dp.sv
rtl/psl_ctrl.sv
rtl/planar_velocity_slew_limiter_top.sv
bench/psl_checker.sv
bench/testbench.sv
